/* rtl/e2c_pkg.sv */
`default_nettype none
package e2c_pkg;

  localparam int unsigned EPOCH_W    = 32;
  localparam int unsigned SEC_DAY    = 86400;
  localparam int unsigned SEC_HOUR   = 3600;
  localparam int unsigned SEC_MIN    = 60;
  localparam int unsigned DAYS_WEEK  = 7;
  localparam int unsigned JDN_EPOCH  = 2440588;
  localparam int unsigned JDN_OFS    = 32044;
  localparam int unsigned DAYS_400Y  = 146097;
  localparam int unsigned DAYS_4Y    = 1461;
  localparam int unsigned MDAY_153   = 153;
  localparam int unsigned YEAR_BASE  = 4800;
  localparam int unsigned YEAR_REF   = 2000;
  // march-based month index at which january starts
  localparam int unsigned MON_JAN    = 10;

  // day of a march-based year on which month m begins, (153 m + 2) / 5
  function automatic logic [8:0] mar_day_offset(input logic [3:0] m);
    logic [8:0] ofs;
    case (m)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage
`default_nettype wire

/* rtl/epoch_to_calendar.sv */
`default_nettype none
// channel   direction  handshake        payload
// command   in         start_i/busy_o   epoch_seconds_i
// result    out        done_o strobe    year, month, day, weekday, hour, minute, second
//
// fully pipelined: one item per cycle
// the pipeline is the chain days -> century -> year in century -> month,
// each constant divider three stages deep
// busy_o is always low; done_o is high for one cycle per item
// the receiver cannot stall, so the pipeline never holds
// reset clears only the valid bits; no clearing pass
module epoch_to_calendar (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [e2c_pkg::EPOCH_W-1:0]  epoch_seconds_i,
  output logic                              done_o,
  output logic signed [7:0]                 year_since_2000_o,
  output logic      [3:0]                   month_number_o,
  output logic      [4:0]                   day_of_month_o,
  output logic      [2:0]                   weekday_index_o,
  output logic      [4:0]                   hour_of_day_o,
  output logic      [5:0]                   minute_of_hour_o,
  output logic      [5:0]                   second_of_minute_o
);
  import e2c_pkg::*;

  localparam int unsigned DAY_W  = $clog2(((64'd1 << EPOCH_W) / SEC_DAY) + 1);
  localparam int unsigned TOD_W  = $clog2(SEC_DAY);
  localparam int unsigned HR_W   = $clog2(((64'd1 << TOD_W) / SEC_HOUR) + 1);
  localparam int unsigned HRR_W  = $clog2(SEC_HOUR);
  localparam int unsigned MN_W   = $clog2(((64'd1 << HRR_W) / SEC_MIN) + 1);
  localparam int unsigned SC_W   = $clog2(SEC_MIN);
  localparam int unsigned WK_W   = $clog2(DAYS_WEEK);
  localparam int unsigned WD_OFS = JDN_EPOCH % DAYS_WEEK;
  localparam int unsigned A_OFS  = JDN_EPOCH + JDN_OFS;
  localparam int unsigned A_W    = $clog2(A_OFS + (64'd1 << DAY_W));
  localparam int unsigned B_LO   = (4 * A_OFS + 3) / DAYS_400Y;
  localparam longint unsigned B1_LIM = longint'(B_LO + 1) * DAYS_400Y;
  localparam longint unsigned B2_LIM = longint'(B_LO + 2) * DAYS_400Y;
  localparam longint unsigned C_OFS0 = (longint'(B_LO) * DAYS_400Y) / 4;
  localparam longint unsigned C_OFS1 = (longint'(B_LO + 1) * DAYS_400Y) / 4;
  localparam longint unsigned C_OFS2 = (longint'(B_LO + 2) * DAYS_400Y) / 4;
  localparam int unsigned C_W    = $clog2(DAYS_400Y / 4 + 2);
  localparam int unsigned X4_W   = C_W + 2;
  localparam int unsigned DQ_W   = $clog2(((64'd1 << X4_W) / DAYS_4Y) + 1);
  localparam int unsigned E_W    = $clog2(DAYS_4Y / 4 + 1);
  localparam int unsigned T_W    = E_W + 3;
  localparam int unsigned MQ_W   = $clog2(((64'd1 << T_W) / MDAY_153) + 1);
  localparam int          Y_OFS  = 100 * int'(B_LO) - int'(YEAR_BASE) - int'(YEAR_REF);
  localparam int unsigned LAT    = 14;

  // stage 3: day count and time of day
  logic             v3;
  logic [DAY_W-1:0] days3;
  logic [TOD_W-1:0] tod3;

  e2c_cdiv #(.W(EPOCH_W), .D(SEC_DAY)) u_day (
    .clk_i, .rst_ni,
    .valid_i (start_i),
    .num_i   (epoch_seconds_i),
    .valid_o (v3),
    .quot_o  (days3),
    .rem_o   (tod3)
  );

  // time of day
  logic [HR_W-1:0]  hour6;
  logic [HRR_W-1:0] sfh6;
  logic [MN_W-1:0]  min9;
  logic [SC_W-1:0]  sec9;
  logic             v6_t;
  logic [HR_W-1:0]  hour13;
  logic [MN_W-1:0]  min13;
  logic [SC_W-1:0]  sec13;

  e2c_cdiv #(.W(TOD_W), .D(SEC_HOUR)) u_hour (
    .clk_i, .rst_ni,
    .valid_i (v3),
    .num_i   (tod3),
    .valid_o (v6_t),
    .quot_o  (hour6),
    .rem_o   (sfh6)
  );

  e2c_cdiv #(.W(HRR_W), .D(SEC_MIN)) u_min (
    .clk_i, .rst_ni,
    .valid_i (v6_t),
    .num_i   (sfh6),
    .valid_o (),
    .quot_o  (min9),
    .rem_o   (sec9)
  );

  e2c_dly #(.W(HR_W), .N(7)) u_dly_hour (.clk_i, .d_i(hour6), .q_o(hour13));
  e2c_dly #(.W(MN_W + SC_W), .N(4)) u_dly_ms (
    .clk_i, .d_i({min9, sec9}), .q_o({min13, sec13})
  );

  // weekday from the day count
  logic [WK_W-1:0] wk6, wk13;

  e2c_cdiv #(.W(DAY_W), .D(DAYS_WEEK)) u_week (
    .clk_i, .rst_ni,
    .valid_i (v3),
    .num_i   (days3),
    .valid_o (),
    .quot_o  (),
    .rem_o   (wk6)
  );

  e2c_dly #(.W(WK_W), .N(7)) u_dly_wk (.clk_i, .d_i(wk6), .q_o(wk13));

  // stage 4: shifted day number and century select
  logic [A_W-1:0]  a_d, a_q;
  logic [A_W+1:0]  x4;
  logic            ge1_q, ge2_q;
  logic            v4_q;

  assign a_d = A_W'(days3) + A_W'(A_OFS);
  assign x4  = {a_d, 2'b11};

  // stage 5: day within the century
  logic [1:0]      bsel_d, bsel_q;
  logic [A_W-1:0]  cofs;
  logic [C_W-1:0]  c_d, c_q;
  logic            v5_q;

  always_comb begin
    bsel_d = 2'd0;
    cofs   = A_W'(C_OFS0);
    if (ge2_q) begin
      bsel_d = 2'd2;
      cofs   = A_W'(C_OFS2);
    end else if (ge1_q) begin
      bsel_d = 2'd1;
      cofs   = A_W'(C_OFS1);
    end
  end

  assign c_d = C_W'(a_q - cofs);

  // stage 8: year within the century
  logic            v8;
  logic [DQ_W-1:0] d8;
  logic [C_W-1:0]  c8;

  e2c_cdiv #(.W(X4_W), .D(DAYS_4Y)) u_yic (
    .clk_i, .rst_ni,
    .valid_i (v5_q),
    .num_i   ({c_q, 2'b11}),
    .valid_o (v8),
    .quot_o  (d8),
    .rem_o   ()
  );

  e2c_dly #(.W(C_W), .N(3)) u_dly_c (.clk_i, .d_i(c_q), .q_o(c8));

  // stage 9: day within the march-based year
  logic [X4_W-1:0] yd;
  logic [E_W-1:0]  e_d, e_q;
  logic [DQ_W-1:0] d_q;
  logic            v9_q;

  assign yd  = X4_W'(d8) * X4_W'(DAYS_4Y);
  assign e_d = E_W'(c8 - C_W'(yd >> 2));

  // stage 10: month scaling
  logic [T_W-1:0]  t_d, t_q;
  logic [E_W-1:0]  e2_q;
  logic            v10_q;

  assign t_d = {e_q, 2'b00} + T_W'(e_q) + T_W'(2);

  // stage 13: march-based month
  logic            v13;
  logic [MQ_W-1:0] m13;
  logic [E_W-1:0]  e13;
  logic [DQ_W-1:0] d13;
  logic [1:0]      bsel13;

  e2c_cdiv #(.W(T_W), .D(MDAY_153)) u_mon (
    .clk_i, .rst_ni,
    .valid_i (v10_q),
    .num_i   (t_q),
    .valid_o (v13),
    .quot_o  (m13),
    .rem_o   ()
  );

  e2c_dly #(.W(E_W), .N(3)) u_dly_e (.clk_i, .d_i(e2_q), .q_o(e13));
  e2c_dly #(.W(DQ_W), .N(4)) u_dly_d (.clk_i, .d_i(d_q), .q_o(d13));
  e2c_dly #(.W(2), .N(8)) u_dly_b (.clk_i, .d_i(bsel_q), .q_o(bsel13));

  // stage 14: output register
  logic        jan_feb;
  logic [7:0]  year_d;
  logic [3:0]  month_d;
  logic [8:0]  mday_full;
  logic [3:0]  wk_sum;
  logic [2:0]  wd_d;
  logic        v14_q;

  // march-based index: march is 0, so months before january add three
  assign jan_feb   = m13 >= MQ_W'(MON_JAN);
  assign month_d   = jan_feb ? 4'(m13) - 4'(MON_JAN - 1) : 4'(m13) + 4'(13 - MON_JAN);
  assign mday_full = 9'(e13) - mar_day_offset(4'(m13)) + 9'd1;
  assign year_d    = 8'(Y_OFS) + 8'(8'(bsel13) * 8'd100) + 8'(d13) + 8'(jan_feb);
  assign wk_sum    = 4'(wk13) + 4'(WD_OFS);
  assign wd_d      = (wk_sum >= 4'(DAYS_WEEK)) ? 3'(wk_sum - 4'(DAYS_WEEK)) : 3'(wk_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v14_q <= 1'b0;
    end else begin
      v4_q  <= v3;
      v5_q  <= v4_q;
      v9_q  <= v8;
      v10_q <= v9_q;
      v14_q <= v13;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q                <= a_d;
    ge1_q              <= x4 >= (A_W+2)'(B1_LIM);
    ge2_q              <= x4 >= (A_W+2)'(B2_LIM);
    bsel_q             <= bsel_d;
    c_q                <= c_d;
    e_q                <= e_d;
    d_q                <= d8;
    t_q                <= t_d;
    e2_q               <= e_q;
    year_since_2000_o  <= year_d;
    month_number_o     <= month_d;
    day_of_month_o     <= 5'(mday_full);
    weekday_index_o    <= wd_d;
    hour_of_day_o      <= 5'(hour13);
    minute_of_hour_o   <= 6'(min13);
    second_of_minute_o <= 6'(sec13);
  end

  assign busy_o = 1'b0;
  assign done_o = v14_q;

  // a strobe comes exactly one pipeline depth after each accepted item
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("result strobe missing after accepted item");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##LAT !done_o)
    else $error("result strobe without an accepted item");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (month_number_o >= 4'd1 && month_number_o <= 4'd12 &&
                day_of_month_o >= 5'd1 && weekday_index_o <= 3'd6))
    else $error("date fields out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hour_of_day_o <= 5'd23 && minute_of_hour_o <= 6'd59 &&
                second_of_minute_o <= 6'd59))
    else $error("time fields out of range");

endmodule
`default_nettype wire

/* rtl/e2c_dly.sv */
`default_nettype none
module e2c_dly #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 2
) (
  input  wire logic         clk_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    sr_q[0] <= d_i;
    for (int i = 1; i < int'(N); i++) begin
      sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[N-1];

endmodule
`default_nettype wire

/* rtl/e2c_cdiv.sv */
`default_nettype none
// divide by a constant in three stages: reciprocal estimate, back-multiply,
// one correction step
module e2c_cdiv #(
  parameter  int unsigned     W  = 16,
  parameter  int unsigned     D  = 10,
  localparam longint unsigned M  = (64'd1 << W) / D,
  localparam int unsigned     QW = $clog2(M + 1),
  localparam int unsigned     RW = $clog2(D),
  localparam int unsigned     NW = RW + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [W-1:0]  num_i,
  output logic               valid_o,
  output logic      [QW-1:0] quot_o,
  output logic      [RW-1:0] rem_o
);

  logic [W+QW-1:0] prod;
  logic [QW-1:0]   q1_d, q1_q, q2_q;
  logic [NW-1:0]   x1_q, x2_q;
  logic [NW-1:0]   p_d, p_q;
  logic [NW-1:0]   r;
  logic            ge;
  logic [QW-1:0]   quot_d;
  logic [RW-1:0]   rem_d;
  logic [2:0]      v_q;

  // estimate is the true quotient or one less
  assign prod = (W+QW)'(num_i) * (W+QW)'(M);
  assign q1_d = prod[W+QW-1:W];

  // remainder stays below twice the divisor, so the low bits suffice
  assign p_d = NW'(q1_q) * NW'(D);

  assign r      = x2_q - p_q;
  assign ge     = r >= NW'(D);
  assign quot_d = q2_q + QW'(ge);
  assign rem_d  = ge ? RW'(r - NW'(D)) : RW'(r);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q   <= q1_d;
    x1_q   <= NW'(num_i);
    q2_q   <= q1_q;
    x2_q   <= x1_q;
    p_q    <= p_d;
    quot_o <= quot_d;
    rem_o  <= rem_d;
  end

  assign valid_o = v_q[2];

endmodule
`default_nettype wire
